### hdl/smis_pkg.sv
// shared types, constants and pixel blend function for the stencil masked scaler
// no dependencies
`default_nettype none

package smis_pkg;

  localparam int SRC_AW   = 16;
  localparam int FRAME_AW = 16;
  localparam int DIM_W    = 9;
  localparam int STEP_W   = 25;
  localparam int START_W  = 17;
  localparam int PROD_W   = STEP_W + 8;
  localparam int POS_W    = PROD_W + 1;
  localparam int CNT_W    = 17;
  localparam int STEN_AW  = FRAME_AW - 5;
  localparam int QDEPTH   = 2;
  localparam int QAW      = 1;
  localparam int DCNT_W   = 5;

  localparam logic [DIM_W-1:0] MAX_DIM   = 9'd256;
  localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1ffff;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_START  = 2'd1,
    KIND_RENDER = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_SRC_W  = 3'd1,
    REG_SRC_H  = 3'd2,
    REG_TGT_W  = 3'd3,
    REG_TGT_H  = 3'd4,
    REG_LEFT   = 3'd5,
    REG_ROWB   = 3'd6,
    REG_PITCH  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                busy;
    logic                mode;
    logic                zoom;
    logic [DIM_W-1:0]    sw;
    logic [DIM_W-1:0]    tw;
    logic [DIM_W-1:0]    th;
    logic [7:0]          left;
    logic [7:0]          row_base;
    logic [DIM_W-1:0]    pitch;
    logic [STEP_W-1:0]   step_x;
    logic [STEP_W-1:0]   step_y;
    logic [START_W-1:0]  start_x;
    logic [START_W-1:0]  start_y;
  } cfg_t;

  typedef struct packed {
    kind_t               kind;
    logic                bil;
    logic [FRAME_AW-1:0] fa;
    logic [SRC_AW-1:0]   a_top;
    logic [SRC_AW-1:0]   a_low;
    logic [7:0]          wx;
    logic [7:0]          wy;
    logic [31:0]         pix;
  } task_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ADD,
    F_ADR
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_STEN,
    B_RD1,
    B_RD2,
    B_RD3,
    B_RD4,
    B_MIX,
    B_OUT
  } back_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = 9'd1;
    else if (v > MAX_DIM) r = MAX_DIM;
    return r;
  endfunction

  // per byte: (a*(256-w) + b*w) >> 8
  function automatic logic [31:0] lerp4(logic [31:0] a, logic [31:0] b, logic [7:0] w);
    logic [8:0]  w0;
    logic [16:0] s;
    logic [31:0] r;
    w0 = 9'd256 - {1'b0, w};
    r  = '0;
    for (int i = 0; i < 4; i++) begin
      s = {9'b0, a[8*i +: 8]} * {8'b0, w0} + {9'b0, b[8*i +: 8]} * {9'b0, w};
      r[8*i +: 8] = s[15:8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/smis_if.sv
// item channels of the scaler: input items and result items
// depends on smis_pkg
`default_nettype none

interface smis_in_if import smis_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [SRC_AW-1:0] source_address;
  logic [31:0]       source_pixel;
  logic [7:0]        column;
  logic [7:0]        row;

  modport source (output valid, kind, source_address, source_pixel, column, row,
                  input ready);
  modport sink (input valid, kind, source_address, source_pixel, column, row,
                output ready);
endinterface

interface smis_out_if import smis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FRAME_AW-1:0] frame_address;
  logic [31:0]         pixel;
  logic                written;
  logic [CNT_W-1:0]    write_count;

  modport source (output valid, frame_address, pixel, written, write_count,
                  input ready);
  modport sink (input valid, frame_address, pixel, written, write_count,
                output ready);
endinterface

`default_nettype wire

### hdl/smis_cfg.sv
// configuration registers and serial divider for scale steps and start offsets
// depends on smis_pkg
`default_nettype none

module smis_cfg import smis_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire reg_idx_t         cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic             mode;
  logic [DIM_W-1:0] sw_raw, sh_raw, tw_raw, th_raw, pitch;
  logic [7:0]       left, row_base;

  logic [DIM_W-1:0] sw, sh, tw, th;

  logic               busy, ld;
  logic [1:0]         job;
  logic [DCNT_W-1:0]  cnt;
  logic [STEP_W-1:0]  num, quo, job_num, qn;
  logic [DIM_W-1:0]   den, job_den;
  logic [DIM_W-1:0]   rem;
  logic [DIM_W:0]     trial;
  logic               qbit;
  logic [STEP_W-1:0]  step_x, step_y;
  logic [START_W-1:0] start_x, start_y;

  assign sw = clamp_dim(sw_raw);
  assign sh = clamp_dim(sh_raw);
  assign tw = clamp_dim(tw_raw);
  assign th = clamp_dim(th_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= 1'b0;
      sw_raw   <= 9'd1;
      sh_raw   <= 9'd1;
      tw_raw   <= 9'd1;
      th_raw   <= 9'd1;
      left     <= '0;
      row_base <= '0;
      pitch    <= 9'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode     <= cfg_data[0];
        REG_SRC_W: sw_raw   <= cfg_data;
        REG_SRC_H: sh_raw   <= cfg_data;
        REG_TGT_W: tw_raw   <= cfg_data;
        REG_TGT_H: th_raw   <= cfg_data;
        REG_LEFT:  left     <= cfg_data[7:0];
        REG_ROWB:  row_base <= cfg_data[7:0];
        REG_PITCH: pitch    <= cfg_data;
      endcase
    end
  end

  // numerator and divisor of each of the four divisions
  always_comb begin
    job_num = '0;
    job_den = sw;
    case (job)
      2'd0: begin
        job_num = mode ? {sw, 16'b0} - {16'b0, sw} : {sw, 16'b0};
        job_den = tw;
      end
      2'd1: begin
        job_num = mode ? {sh, 16'b0} - {16'b0, sh} : {sh, 16'b0};
        job_den = th;
      end
      2'd2: begin
        if (mode && tw < sw) job_num = {sw - tw, 16'b0};
        job_den = sw;
      end
      default: begin
        if (mode && th < sh) job_num = {sh - th, 16'b0};
        job_den = sh;
      end
    endcase
  end

  assign trial = {rem, num[STEP_W-1]};
  assign qbit  = trial >= {1'b0, den};
  assign qn    = {quo[STEP_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      ld   <= 1'b1;
      job  <= '0;
    end else if (cfg_we) begin
      busy <= 1'b1;
      ld   <= 1'b1;
      job  <= '0;
    end else if (busy) begin
      if (ld) begin
        num <= job_num;
        den <= job_den;
        rem <= '0;
        quo <= '0;
        cnt <= '0;
        ld  <= 1'b0;
      end else begin
        num <= {num[STEP_W-2:0], 1'b0};
        rem <= qbit ? DIM_W'(trial - {1'b0, den}) : trial[DIM_W-1:0];
        quo <= qn;
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(STEP_W - 1)) begin
          case (job)
            2'd0:    step_x  <= qn;
            2'd1:    step_y  <= qn;
            2'd2:    start_x <= qn[START_W-1:0];
            default: start_y <= qn[START_W-1:0];
          endcase
          if (job == 2'd3) begin
            busy <= 1'b0;
          end else begin
            job <= job + 1'b1;
            ld  <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    cfg.busy     = busy;
    cfg.mode     = mode;
    cfg.zoom     = (tw >= sw) || (th >= sh);
    cfg.sw       = sw;
    cfg.tw       = tw;
    cfg.th       = th;
    cfg.left     = left;
    cfg.row_base = row_base;
    cfg.pitch    = pitch;
    cfg.step_x   = step_x;
    cfg.step_y   = step_y;
    cfg.start_x  = start_x;
    cfg.start_y  = start_y;
  end

endmodule

`default_nettype wire

### hdl/smis_front.sv
// front end: accepts items and computes frame and source addresses and weights
// depends on smis_pkg, smis_if
`default_nettype none

module smis_front import smis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  smis_in_if.sink   in_ch,
  input  wire cfg_t cfg,
  input  wire logic q_full,
  output logic      push,
  output task_t     tsk
);

  front_state_t state, state_next;

  kind_t             it_kind;
  logic [SRC_AW-1:0] it_addr;
  logic [31:0]       it_pix;
  logic [7:0]        it_col, it_row;

  logic [FRAME_AW-1:0] fa_mul, fa;
  logic [PROD_W-1:0]   mx, my;
  logic [POS_W-1:0]    xx, yy;
  logic [SRC_AW-1:0]   xi, yprod, top, low;
  logic [7:0]          wx, wy;
  logic                last_col, last_row;
  logic [15:0]         rel;

  assign in_ch.ready = (state == F_IDLE) && !cfg.busy;

  assign rel = {8'b0, cfg.row_base} - {8'b0, it_row};
  assign xx  = {{(POS_W-START_W){1'b0}}, cfg.start_x} + {1'b0, mx};
  assign yy  = {{(POS_W-START_W){1'b0}}, cfg.start_y} + {1'b0, my};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    unique case (state)
      F_IDLE: if (in_ch.valid && in_ch.ready) state_next = F_MUL;
      F_MUL:  state_next = F_ADD;
      F_ADD:  state_next = F_ADR;
      F_ADR: begin
        push = !q_full;
        if (!q_full) state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        it_kind <= kind_t'(in_ch.kind);
        it_addr <= in_ch.source_address;
        it_pix  <= in_ch.source_pixel;
        it_col  <= in_ch.column;
        it_row  <= in_ch.row;
      end
      F_MUL: begin
        fa_mul <= 16'(rel * {7'b0, cfg.pitch});
        mx     <= {{(PROD_W-STEP_W){1'b0}}, cfg.step_x} * {{(PROD_W-8){1'b0}}, it_col};
        my     <= {{(PROD_W-STEP_W){1'b0}}, cfg.step_y} * {{(PROD_W-8){1'b0}}, it_row};
      end
      F_ADD: begin
        fa       <= fa_mul + {8'b0, cfg.left} + {8'b0, it_col};
        xi       <= xx[31:16];
        yprod    <= 16'(yy[31:16] * {7'b0, cfg.sw});
        wx       <= xx[15:8];
        wy       <= yy[15:8];
        last_col <= {1'b0, it_col} >= cfg.tw - 1'b1;
        last_row <= {1'b0, it_row} >= cfg.th - 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    top = yprod + xi;
    if (cfg.mode && cfg.zoom && last_col) top = top - 1'b1;
    low = (cfg.zoom && last_row) ? top : top + {7'b0, cfg.sw};
    tsk.kind  = it_kind;
    tsk.bil   = cfg.mode;
    tsk.fa    = fa;
    tsk.a_top = (it_kind == KIND_LOAD) ? it_addr : top;
    tsk.a_low = low;
    tsk.wx    = wx;
    tsk.wy    = wy;
    tsk.pix   = it_pix;
  end

endmodule

`default_nettype wire

### hdl/smis_queue.sv
// short queue of classified items between front and back end
// depends on smis_pkg
`default_nettype none

module smis_queue import smis_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire task_t din,
  input  wire logic  pop,
  output task_t      dout,
  output logic       full,
  output logic       empty
);

  task_t          ent [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   cnt;

  assign full  = cnt == (QAW+1)'(QDEPTH);
  assign empty = cnt == '0;
  assign dout  = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= din;
  end

endmodule

`default_nettype wire

### hdl/smis_back.sv
// back end: source store, stencil store, write count, blending and result register
// depends on smis_pkg, smis_if
`default_nettype none

module smis_back import smis_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire task_t head,
  input  wire logic  q_empty,
  output logic       pop,
  smis_out_if.source out_ch
);

  back_state_t state, state_next;

  task_t              cur;
  logic [STEN_AW-1:0] clr_addr;
  logic               from_frame;
  logic [CNT_W-1:0]   count;
  logic [FRAME_AW-1:0] res_fa;
  logic [31:0]        res_pix;
  logic               res_written;
  logic [31:0]        p00, p01, p10, h0, h1;

  logic [31:0]        sten_mem [2**STEN_AW];
  logic               sten_we;
  logic [STEN_AW-1:0] sten_addr;
  logic [31:0]        sten_wd, sten_rd, bit_mask;

  logic [31:0]        src_mem [2**SRC_AW];
  logic               src_we;
  logic [SRC_AW-1:0]  src_addr;
  logic [31:0]        src_wd, src_rd;

  logic hit;

  assign bit_mask = 32'd1 << cur.fa[4:0];
  assign hit      = |(sten_rd & bit_mask);

  always_ff @(posedge clk) begin
    if (sten_we) sten_mem[sten_addr] <= sten_wd;
    sten_rd <= sten_mem[sten_addr];
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_addr] <= src_wd;
    src_rd <= src_mem[src_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    sten_we    = 1'b0;
    sten_addr  = cur.fa[FRAME_AW-1:5];
    sten_wd    = sten_rd | bit_mask;
    src_we     = 1'b0;
    src_addr   = cur.a_top;
    src_wd     = cur.pix;
    unique case (state)
      B_CLEAR: begin
        sten_we   = 1'b1;
        sten_addr = clr_addr;
        sten_wd   = '0;
        if (&clr_addr) state_next = from_frame ? B_OUT : B_IDLE;
      end
      B_IDLE: begin
        sten_addr = head.fa[FRAME_AW-1:5];
        src_addr  = head.a_top;
        src_wd    = head.pix;
        if (!q_empty) begin
          pop = 1'b1;
          unique case (head.kind)
            KIND_LOAD: begin
              src_we     = 1'b1;
              state_next = B_OUT;
            end
            KIND_START:  state_next = B_CLEAR;
            KIND_RENDER: state_next = B_STEN;
            KIND_SPARE:  state_next = B_OUT;
          endcase
        end
      end
      B_STEN: begin
        if (hit) begin
          state_next = B_OUT;
        end else begin
          sten_we    = 1'b1;
          state_next = B_RD1;
        end
      end
      B_RD1: begin
        src_addr   = cur.a_top + 1'b1;
        state_next = cur.bil ? B_RD2 : B_OUT;
      end
      B_RD2: begin
        src_addr   = cur.a_low;
        state_next = B_RD3;
      end
      B_RD3: begin
        src_addr   = cur.a_low + 1'b1;
        state_next = B_RD4;
      end
      B_RD4: state_next = B_MIX;
      B_MIX: state_next = B_OUT;
      B_OUT: if (out_ch.ready) state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      from_frame <= 1'b0;
      count      <= '0;
    end else begin
      case (state)
        B_CLEAR: clr_addr <= clr_addr + 1'b1;
        B_IDLE: begin
          if (!q_empty && head.kind == KIND_START) begin
            count      <= '0;
            from_frame <= 1'b1;
            clr_addr   <= '0;
          end
        end
        B_STEN: if (!hit && count != COUNT_MAX) count <= count + 1'b1;
        B_OUT:  if (out_ch.ready) from_frame <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur         <= head;
        res_fa      <= '0;
        res_pix     <= '0;
        res_written <= 1'b0;
      end
      B_STEN: begin
        res_fa      <= cur.fa;
        res_written <= !hit;
      end
      B_RD1: begin
        p00 <= src_rd;
        if (!cur.bil) res_pix <= src_rd;
      end
      B_RD2: p01 <= src_rd;
      B_RD3: p10 <= src_rd;
      B_RD4: begin
        h0 <= lerp4(p00, p01, cur.wx);
        h1 <= lerp4(p10, src_rd, cur.wx);
      end
      B_MIX: res_pix <= lerp4(h0, h1, cur.wy);
      default: ;
    endcase
  end

  assign out_ch.valid         = state == B_OUT;
  assign out_ch.frame_address = res_fa;
  assign out_ch.pixel         = res_pix;
  assign out_ch.written       = res_written;
  assign out_ch.write_count   = count;

endmodule

`default_nettype wire

### hdl/stencil_masked_image_scaler_unit.sv
// front end takes a new item only after pushing the previous one; items pass a 2-entry queue to the back end
// back end: load or other, masked render, nearest render, bilinear render
// (four reads of the single-port source store); start frame runs a stencil sweep
// plus a result; each result holds in the output register until taken
// reset: stencil sweep and a step division, which also follows
// every configuration write, with input ready low until done
`default_nettype none

module stencil_masked_image_scaler_unit import smis_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  smis_in_if.sink               in_ch,
  smis_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data
);

  cfg_t  cfg;
  task_t q_in, q_out;
  logic  push, pop, q_full, q_empty;

  smis_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (reg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  smis_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .tsk    (q_in)
  );

  smis_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_in),
    .pop   (pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  smis_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_out),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg.busy |-> !in_ch.ready)
    else $error("item accepted during step computation");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.written |-> out_ch.write_count != '0)
    else $error("written result with zero count");

  a_masked_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.written |-> out_ch.pixel == '0)
    else $error("unwritten result carries a pixel");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire
